>>> hdl/kst_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// kst_pkg: shared types and constants of the keyed sum table
// Sizes, request codes, sequencer states, RAM request and result records,
// and key trimming.
// ----------------------------------------------------------------------------
package kst_pkg;

  localparam int ENTRIES   = 64;
  localparam int IDX_W     = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int CNT_W     = $clog2(ENTRIES + 1);
  localparam int KEY_BYTES = 19;
  localparam int KEY_W     = 8 * KEY_BYTES;
  localparam int TOTAL_W   = 32;
  localparam int ENTRY_W   = KEY_W + TOTAL_W;

  localparam logic REQ_ADD   = 1'b0;
  localparam logic REQ_QUERY = 1'b1;

  localparam logic signed [TOTAL_W-1:0] TOTAL_MAX = {1'b0, {(TOTAL_W-1){1'b1}}};
  localparam logic signed [TOTAL_W-1:0] TOTAL_MIN = {1'b1, {(TOTAL_W-1){1'b0}}};

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_UPDATE,
    S_OUT
  } kst_state_t;

  typedef struct packed {
    logic               rd_en;
    logic [IDX_W-1:0]   rd_addr;
    logic               wr_en;
    logic [IDX_W-1:0]   wr_addr;
    logic [ENTRY_W-1:0] wr_data;
  } kst_ram_req_t;

  typedef struct packed {
    logic signed [TOTAL_W-1:0] total;
    logic                      found;
    logic                      inserted_new;
    logic                      dropped;
    logic                      saturated;
  } kst_result_t;

  // Clear every byte after the first zero byte.
  function automatic logic [KEY_W-1:0] trim_key(input logic [KEY_W-1:0] k);
    logic             alive;
    logic [KEY_W-1:0] r;
    alive = 1'b1;
    r     = '0;
    for (int b = 0; b < KEY_BYTES; b++) begin
      if (k[8*b +: 8] == 8'h00) begin
        alive = 1'b0;
      end
      r[8*b +: 8] = alive ? k[8*b +: 8] : 8'h00;
    end
    return r;
  endfunction

endpackage
`default_nettype wire

>>> hdl/kst_ram.sv
`default_nettype none
// ----------------------------------------------------------------------------
// kst_ram: generic single-write, single-read RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module kst_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic              clk,
  input  wire logic              wr_en,
  input  wire logic [ADDR_W-1:0] wr_addr,
  input  wire logic [WIDTH-1:0]  wr_data,
  input  wire logic              rd_en,
  input  wire logic [ADDR_W-1:0] rd_addr,
  output logic      [WIDTH-1:0]  rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule
`default_nettype wire

>>> hdl/kst_ctrl.sv
`default_nettype none
// ----------------------------------------------------------------------------
// kst_ctrl: scan sequencer and update unit of the keyed sum table
// Walks stored keys one per cycle through the RAM read port, compares each
// with the request key, then accumulates, inserts, drops or answers.
// ----------------------------------------------------------------------------
module kst_ctrl (
  input  wire logic                         clk,
  input  wire logic                         rst,
  input  wire logic                         in_valid,
  output logic                              in_stall,
  input  wire logic                         req_type,
  input  wire logic [kst_pkg::KEY_W-1:0]    key,
  input  wire logic signed [31:0]           amount,
  output kst_pkg::kst_ram_req_t             ram_req,
  input  wire logic [kst_pkg::ENTRY_W-1:0]  ram_rd_data,
  output logic                              res_valid,
  output kst_pkg::kst_result_t              res,
  input  wire logic                         res_take
);
  import kst_pkg::*;

  kst_state_t state, state_next;

  logic [KEY_W-1:0]          key_r;
  logic signed [TOTAL_W-1:0] amount_r;
  logic                      is_query;
  logic [CNT_W-1:0]          used;
  logic [CNT_W-1:0]          scan_idx;
  logic                      cmp_valid;
  logic [IDX_W-1:0]          cmp_idx;
  logic                      hit_found;
  logic [IDX_W-1:0]          hit_idx;
  logic signed [TOTAL_W-1:0] hit_total;
  kst_result_t               res_next;

  logic                      accept;
  logic                      match;
  logic                      last;
  logic                      has_room;
  logic signed [TOTAL_W:0]   sum_wide;
  logic signed [TOTAL_W-1:0] sum_sat;
  logic                      sum_ovf;
  logic                      do_insert;

  assign accept   = in_valid && !in_stall;
  assign match    = cmp_valid && (ram_rd_data[ENTRY_W-1 -: KEY_W] == key_r);
  assign last     = cmp_valid && ((CNT_W'(cmp_idx) + CNT_W'(1)) == used);
  assign has_room = used < CNT_W'(ENTRIES);

  // Saturating accumulate.
  always_comb begin
    sum_wide = {hit_total[TOTAL_W-1], hit_total} + {amount_r[TOTAL_W-1], amount_r};
    sum_ovf  = sum_wide[TOTAL_W] != sum_wide[TOTAL_W-1];
    if (!sum_ovf) begin
      sum_sat = sum_wide[TOTAL_W-1:0];
    end else if (sum_wide[TOTAL_W]) begin
      sum_sat = TOTAL_MIN;
    end else begin
      sum_sat = TOTAL_MAX;
    end
  end

  assign do_insert = !is_query && !hit_found && has_room;

  always_comb begin
    res_next = '0;
    if (is_query) begin
      res_next.found = hit_found;
      res_next.total = hit_found ? hit_total : '0;
    end else if (hit_found) begin
      res_next.found     = 1'b1;
      res_next.total     = sum_sat;
      res_next.saturated = sum_ovf;
    end else if (has_room) begin
      res_next.total        = amount_r;
      res_next.inserted_new = 1'b1;
    end else begin
      res_next.dropped = 1'b1;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (in_valid) begin
          state_next = (used == '0) ? S_UPDATE : S_SCAN;
        end
      end
      S_SCAN: begin
        if (match || last) begin
          state_next = S_UPDATE;
        end
      end
      S_UPDATE: state_next = S_OUT;
      S_OUT: begin
        if (res_take) begin
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_comb begin
    in_stall        = state != S_IDLE;
    res_valid       = state == S_OUT;
    ram_req.rd_en   = (state == S_SCAN) && (scan_idx < used);
    ram_req.rd_addr = IDX_W'(scan_idx);
    ram_req.wr_en   = (state == S_UPDATE) && !is_query && (hit_found || has_room);
    ram_req.wr_addr = hit_found ? hit_idx : IDX_W'(used);
    ram_req.wr_data = {key_r, hit_found ? sum_sat : amount_r};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      used  <= '0;
    end else begin
      state <= state_next;
      if (state == S_UPDATE && do_insert) begin
        used <= used + CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      key_r     <= key;
      amount_r  <= amount;
      is_query  <= req_type == REQ_QUERY;
      scan_idx  <= '0;
      cmp_valid <= 1'b0;
      hit_found <= 1'b0;
    end else if (state == S_SCAN) begin
      cmp_valid <= ram_req.rd_en;
      cmp_idx   <= IDX_W'(scan_idx);
      if (ram_req.rd_en) begin
        scan_idx <= scan_idx + CNT_W'(1);
      end
      if (match) begin
        hit_found <= 1'b1;
        hit_idx   <= cmp_idx;
        hit_total <= ram_rd_data[TOTAL_W-1:0];
      end
    end
    if (state == S_UPDATE) begin
      res <= res_next;
    end
  end

  a_used_bound: assert property (@(posedge clk) disable iff (rst)
    used <= CNT_W'(ENTRIES))
    else $error("fill count beyond table size");

  a_used_grows_on_write: assert property (@(posedge clk) disable iff (rst)
    (!$past(rst) && used != $past(used)) |-> ($past(state) == S_UPDATE && $past(ram_req.wr_en)))
    else $error("fill count changed without an insert");

  a_write_in_update: assert property (@(posedge clk) disable iff (rst)
    ram_req.wr_en |-> (state == S_UPDATE))
    else $error("table write outside update");

  a_hit_below_used: assert property (@(posedge clk) disable iff (rst)
    (state == S_UPDATE && hit_found) |-> (CNT_W'(hit_idx) < used))
    else $error("hit index beyond filled entries");

endmodule
`default_nettype wire

>>> hdl/keyed_sum_table_core.sv
`default_nettype none
// ----------------------------------------------------------------------------
// keyed_sum_table_core: group-by-sum table keyed by a 19-byte name
// Adds amounts to per-key totals with saturation, appends new keys, and
// answers total queries.
// ----------------------------------------------------------------------------
// channel  direction  handshake            payload
// in       to core    in_valid / in_stall  req_type, key_part0..2, amount
// out      from core  out_valid / out_stall total, found, inserted_new,
//                                          dropped, saturated
//
// An empty table skips the scan; a hit ends the scan early and a miss scans
// every filled entry. The single RAM read port sets the scan at one stored
// key per cycle.
// Reset clears the fill count, sequencer state and output valid only; no clearing pass.
// A finished result waits in the output register while the next item is taken.
// ----------------------------------------------------------------------------
module keyed_sum_table_core (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               in_valid,
  output logic                    in_stall,
  input  wire logic               req_type,
  input  wire logic [63:0]        key_part0,
  input  wire logic [63:0]        key_part1,
  input  wire logic [23:0]        key_part2,
  input  wire logic signed [31:0] amount,
  output logic                    out_valid,
  input  wire logic               out_stall,
  output logic signed [31:0]      total,
  output logic                    found,
  output logic                    inserted_new,
  output logic                    dropped,
  output logic                    saturated
);
  import kst_pkg::*;

  kst_ram_req_t       ram_req;
  logic [ENTRY_W-1:0] ram_rd_data;
  logic               res_valid;
  kst_result_t        res;
  logic               res_take;
  kst_result_t        out_res;
  logic [KEY_W-1:0]   key_trim;

  assign key_trim = trim_key({key_part2, key_part1, key_part0});
  assign res_take = res_valid && (!out_valid || !out_stall);

  kst_ctrl u_ctrl (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .req_type    (req_type),
    .key         (key_trim),
    .amount      (amount),
    .ram_req     (ram_req),
    .ram_rd_data (ram_rd_data),
    .res_valid   (res_valid),
    .res         (res),
    .res_take    (res_take)
  );

  kst_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (ENTRIES)
  ) u_ram (
    .clk     (clk),
    .wr_en   (ram_req.wr_en),
    .wr_addr (ram_req.wr_addr),
    .wr_data (ram_req.wr_data),
    .rd_en   (ram_req.rd_en),
    .rd_addr (ram_req.rd_addr),
    .rd_data (ram_rd_data)
  );

  // Hold the result until taken.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (res_take) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_take) begin
      out_res <= res;
    end
  end

  assign total        = out_res.total;
  assign found        = out_res.found;
  assign inserted_new = out_res.inserted_new;
  assign dropped      = out_res.dropped;
  assign saturated    = out_res.saturated;

endmodule
`default_nettype wire
